### hw/rtl/stack_bytecode_interpreter_macros.svh
// Assertion macros for the RTL files, included by the controller.
`ifndef STACK_BYTECODE_INTERPRETER_MACROS_SVH
`define STACK_BYTECODE_INTERPRETER_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define SBI_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define SBI_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sbi_pkg.sv
package sbi_pkg;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_PUSH = 8'h01;
  localparam logic [7:0] OP_POP  = 8'h02;
  localparam logic [7:0] OP_ADD  = 8'h10;
  localparam logic [7:0] OP_SUB  = 8'h11;
  localparam logic [7:0] OP_MUL  = 8'h12;
  localparam logic [7:0] OP_DIV  = 8'h13;
  localparam logic [7:0] OP_HALT = 8'hFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_DIVZERO  = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic    rd_a;      // read second entry (addr sp-2) into operand a
    logic    rd_b;      // read top entry (addr sp-1) into operand b
    logic    push_wr;   // write pushed operand at sp
    logic    alu_start; // start arithmetic on a, b
    alu_op_t alu_op;
    logic    res_wr;    // write ALU result at sp-2
    logic    rd_bottom; // read entry 0
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic alu_done;
    logic b_zero;
  } dp_sts_t;

endpackage

### hw/rtl/sbi_ram.sv
module sbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

### hw/rtl/sbi_alu.sv
module sbi_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sbi_pkg::alu_op_t   op,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output logic               done,
  output logic [63:0]        result
);
  import sbi_pkg::*;

  // Multiply: shift-add, 4 bits per cycle (16 steps).
  // Divide: restoring, 1 bit per cycle (64 steps).
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  alu_op_t     op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;   // sum, difference, product, or quotient
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] sa_r, sa_nxt;     // shifting multiplicand / dividend
  logic [63:0] sb_r, sb_nxt;     // multiplier / divisor
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [63:0] pp;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    rem_sh   = {rem_r, sa_r[63]};
    rem_sub  = rem_sh - {1'b0, sb_r};
    pp       = sa_r * {60'd0, sb_r[3:0]};
    if (start) begin
      op_nxt = op;
      case (op)
        ALU_ADD: begin
          acc_nxt  = a + b;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          acc_nxt  = a - b;
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          acc_nxt  = '0;
          sa_nxt   = a;
          sb_nxt   = b;
          cnt_nxt  = 7'd16;
          busy_nxt = 1'b1;
        end
        default: begin
          acc_nxt  = '0;
          rem_nxt  = '0;
          sa_nxt   = a;
          sb_nxt   = b;
          cnt_nxt  = 7'd64;
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        acc_nxt = acc_r + pp;
        sa_nxt  = {sa_r[59:0], 4'd0};
        sb_nxt  = {4'd0, sb_r[63:4]};
      end else begin
        sa_nxt = {sa_r[62:0], 1'b0};
        if (!rem_sub[64]) begin
          rem_nxt = rem_sub[63:0];
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          acc_nxt = {acc_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### hw/rtl/sbi_datapath.sv
module sbi_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbi_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(STACK_DEPTH)-1:0] sp_idx,  // sp, masked to index width
  input  logic [7:0]                     operand,
  output sbi_pkg::dp_sts_t               sts,
  output logic [63:0]                    rd_word
);
  import sbi_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic [63:0]   a_r, a_nxt;
  logic [63:0]   b_r, b_nxt;
  logic          cap_a_r, cap_b_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;
  logic          alu_done;
  logic [63:0]   alu_res;

  always_comb begin
    wr_en   = cmd.push_wr || cmd.res_wr;
    wr_addr = sp_idx;
    wr_data = {56'd0, operand};
    if (cmd.res_wr) begin
      wr_addr = sp_idx - AW'(2);
      wr_data = alu_res;
    end
    rd_addr = '0;
    if (cmd.rd_a) begin
      rd_addr = sp_idx - AW'(1) - AW'(1);
    end else if (cmd.rd_b) begin
      rd_addr = sp_idx - AW'(1);
    end
    a_nxt = cap_a_r ? rd_data : a_r;
    b_nxt = cap_b_r ? rd_data : b_r;
  end

  sbi_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The top entry arrives from the RAM in the start cycle: feed it straight through.
  sbi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.alu_start),
    .op    (cmd.alu_op),
    .a     (a_r),
    .b     (b_nxt),
    .done  (alu_done),
    .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_a_r <= 1'b0;
      cap_b_r <= 1'b0;
    end else begin
      cap_a_r <= cmd.rd_a;
      cap_b_r <= cmd.rd_b;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign sts.alu_done = alu_done;
  assign sts.b_zero   = (b_nxt == 64'd0);
  assign rd_word      = rd_data;

endmodule

### hw/rtl/sbi_ctrl.sv
`include "stack_bytecode_interpreter_macros.svh"
module sbi_ctrl #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_PROGRAM = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    out_value,
  output logic [1:0]                     out_status,
  output logic [4:0]                     out_depth,
  output sbi_pkg::dp_cmd_t               cmd,
  output logic [$clog2(STACK_DEPTH)-1:0] sp_idx,
  output logic [7:0]                     operand,
  input  sbi_pkg::dp_sts_t               sts,
  input  logic [63:0]                    rd_word
);
  import sbi_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int BCW = $clog2(MAX_PROGRAM + 2);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [BCW-1:0] BC_MAX  = BCW'(MAX_PROGRAM);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD_A   = 7'b0000010,
    S_RD_B   = 7'b0000100,
    S_START  = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_FIN_RD = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           await_r, await_nxt;
  logic           stop_r, stop_nxt;
  logic [1:0]     err_r, err_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic           last_r, last_nxt;
  alu_op_t        aop_r, aop_nxt;
  logic           ov_r, ov_nxt;
  logic [63:0]    ov_val_r, ov_val_nxt;
  logic [1:0]     ov_st_r, ov_st_nxt;
  logic [4:0]     ov_dp_r, ov_dp_nxt;
  logic           in_xfer;
  logic           out_xfer;
  logic           too_long;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign too_long = bc_r > BC_MAX;

  always_comb begin
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    await_nxt  = await_r;
    stop_nxt   = stop_r;
    err_nxt    = err_r;
    bc_nxt     = bc_r;
    last_nxt   = last_r;
    aop_nxt    = aop_r;
    ov_nxt     = ov_r && !out_xfer;
    ov_val_nxt = ov_val_r;
    ov_st_nxt  = ov_st_r;
    ov_dp_nxt  = ov_dp_r;
    cmd        = '0;
    cmd.alu_op = aop_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_last;
          if (bc_r <= BC_MAX) begin
            bc_nxt = bc_r + BCW'(1);
          end
          state_nxt = in_last ? S_FIN_RD : S_IDLE;
          if (!stop_r) begin
            if (await_r) begin
              await_nxt = 1'b0;
              if (sp_r < SP_FULL) begin
                cmd.push_wr = 1'b1;
                sp_nxt      = sp_r + SPW'(1);
              end
            end else begin
              case (in_byte)
                OP_NOP: ;
                OP_HALT: stop_nxt = 1'b1;
                OP_PUSH: begin
                  if (sp_r >= SP_FULL) begin
                    stop_nxt = 1'b1;
                    err_nxt  = ST_OVERFLOW;
                  end else if (in_last) begin
                    stop_nxt = 1'b1;
                    err_nxt  = ST_INVALID;
                  end else begin
                    await_nxt = 1'b1;
                  end
                end
                OP_POP: begin
                  if (sp_r == '0) begin
                    stop_nxt = 1'b1;
                    err_nxt  = ST_INVALID;
                  end else begin
                    sp_nxt = sp_r - SPW'(1);
                  end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (sp_r < SPW'(2)) begin
                    stop_nxt = 1'b1;
                    err_nxt  = ST_INVALID;
                  end else begin
                    aop_nxt   = alu_op_t'(in_byte[1:0]);
                    state_nxt = S_RD_A;
                  end
                end
                default: begin
                  stop_nxt = 1'b1;
                  err_nxt  = ST_INVALID;
                end
              endcase
            end
          end
        end
      end
      S_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        if (aop_r == ALU_DIV && sts.b_zero) begin
          stop_nxt  = 1'b1;
          err_nxt   = ST_DIVZERO;
          state_nxt = last_r ? S_FIN_RD : S_IDLE;
        end else begin
          cmd.alu_start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.alu_done) begin
          cmd.res_wr = 1'b1;
          sp_nxt     = sp_r - SPW'(1);
          state_nxt  = last_r ? S_FIN_RD : S_IDLE;
        end
      end
      S_FIN_RD: begin
        cmd.rd_bottom = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // Hold here while the previous result still waits on the output.
        if (!ov_r || out_xfer) begin
          ov_nxt     = 1'b1;
          ov_val_nxt = (!too_long && err_r == ST_OK && sp_r != '0) ? rd_word : 64'd0;
          ov_st_nxt  = too_long ? ST_INVALID : err_r;
          ov_dp_nxt  = too_long ? 5'd0 : 5'(sp_r);
          sp_nxt     = '0;
          await_nxt  = 1'b0;
          stop_nxt   = 1'b0;
          err_nxt    = ST_OK;
          bc_nxt     = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      await_r <= 1'b0;
      stop_r  <= 1'b0;
      err_r   <= ST_OK;
      bc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      await_r <= await_nxt;
      stop_r  <= stop_nxt;
      err_r   <= err_nxt;
      bc_r    <= bc_nxt;
      ov_r    <= ov_nxt;
    end
    last_r   <= last_nxt;
    aop_r    <= aop_nxt;
    ov_val_r <= ov_val_nxt;
    ov_st_r  <= ov_st_nxt;
    ov_dp_r  <= ov_dp_nxt;
  end

  // Push writes the incoming byte directly; otherwise index from the stack pointer.
  assign operand    = in_byte;
  assign sp_idx     = AW'(sp_r);
  assign out_valid  = ov_r;
  assign out_value  = ov_val_r;
  assign out_status = ov_st_r;
  assign out_depth  = ov_dp_r;

  `SBI_ASSERT_IMPL(a_sp_range, clk, rst_n, 1'b1, sp_r <= SP_FULL, "stack pointer beyond depth")
  `SBI_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "input taken while busy")
  `SBI_ASSERT_NEXT(a_fin_out, clk, rst_n, state_r == S_FIN, out_valid, "result not raised")
  `SBI_ASSERT_IMPL(a_wr_excl, clk, rst_n, cmd.res_wr, !cmd.push_wr, "two stack writes")

endmodule

### hw/rtl/stack_bytecode_interpreter.sv
// Sequencing: nop/push/pop/halt are handled as each byte is accepted; add/sub/mul/div
// step through S_RD_A, S_RD_B, S_START and S_WAIT (div: 1 quotient bit per cycle in the divider).
// The final byte reads the bottom stack word (S_FIN_RD, S_FIN) before the result is shown;
// a result still waiting on the output holds the next final byte until it is taken.
// Throughput: one byte per cycle for stack moves while the controller is idle; input is
// held off while arithmetic uses the shared arithmetic unit and while a final byte is finished.
// Reset: synchronous active-low rst_n clears pointer, flags, status and counters.
module stack_bytecode_interpreter #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_PROGRAM = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] result_value, [65:64] status, [70:66] final_depth
);
  import sbi_pkg::*;

  dp_cmd_t                    cmd;
  dp_sts_t                    sts;
  logic [$clog2(STACK_DEPTH)-1:0] sp_idx;
  logic [7:0]                 operand;
  logic [63:0]                rd_word;
  logic [63:0]                res_value;
  logic [1:0]                 res_status;
  logic [4:0]                 res_depth;

  // Controller: decode each transfer, sequence stack reads and arithmetic.
  sbi_ctrl #(.STACK_DEPTH(STACK_DEPTH), .MAX_PROGRAM(MAX_PROGRAM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (res_value),
    .out_status(res_status),
    .out_depth (res_depth),
    .cmd       (cmd),
    .sp_idx    (sp_idx),
    .operand   (operand),
    .sts       (sts),
    .rd_word   (rd_word)
  );

  // Datapath: stack RAM, operand registers and arithmetic unit.
  sbi_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sp_idx (sp_idx),
    .operand(operand),
    .sts    (sts),
    .rd_word(rd_word)
  );

  // Pack the result, padded with zeros to whole bytes.
  assign out_tdata = {1'b0, res_depth, res_status, res_value};

endmodule

### bench/tb_stack_bytecode_interpreter.sv
`timescale 1ns / 1ps

// Scoreboard: replays each accepted program byte through a behavioural copy of
// the interpreter and keeps the results that must appear on the output stream.
class interp_scoreboard;
  localparam int DEPTH   = 16;
  localparam int MAXPROG = 1024;

  logic [63:0] stk [DEPTH];
  int unsigned sp;
  bit          want_operand;
  bit          halted;
  logic [1:0]  err;
  int unsigned nbytes;
  logic [71:0] pending_results [$];
  int unsigned n_errors;
  int unsigned n_checked;

  function void clear_state();
    sp = 0;
    want_operand = 0;
    halted = 0;
    err = sbi_pkg::ST_OK;
    nbytes = 0;
  endfunction

  function void stop_with(logic [1:0] code);
    err = code;
    halted = 1;
  endfunction

  function void run_opcode(logic [7:0] op, bit is_last);
    logic [63:0] a, b;
    case (op)
      sbi_pkg::OP_NOP: ;
      sbi_pkg::OP_HALT: halted = 1;
      sbi_pkg::OP_PUSH: begin
        if (sp >= DEPTH) stop_with(sbi_pkg::ST_OVERFLOW);
        else if (is_last) stop_with(sbi_pkg::ST_INVALID);
        else want_operand = 1;
      end
      sbi_pkg::OP_POP: begin
        if (sp == 0) stop_with(sbi_pkg::ST_INVALID);
        else sp--;
      end
      sbi_pkg::OP_ADD, sbi_pkg::OP_SUB, sbi_pkg::OP_MUL, sbi_pkg::OP_DIV: begin
        if (sp < 2) begin
          stop_with(sbi_pkg::ST_INVALID);
          return;
        end
        a = stk[sp-2];
        b = stk[sp-1];
        if (op == sbi_pkg::OP_DIV && b == 64'd0) begin
          stop_with(sbi_pkg::ST_DIVZERO);
          return;
        end
        case (op)
          sbi_pkg::OP_ADD: a = a + b;
          sbi_pkg::OP_SUB: a = a - b;
          sbi_pkg::OP_MUL: a = a * b;
          default:         a = a / b;
        endcase
        stk[sp-2] = a;
        sp--;
      end
      default: stop_with(sbi_pkg::ST_INVALID);
    endcase
  endfunction

  // Note one accepted input transfer; queue a result on the last byte.
  function void note_byte(logic [7:0] code, bit is_last);
    logic [63:0] value;
    logic [1:0]  status;
    logic [4:0]  depth;
    if (nbytes <= MAXPROG) nbytes++;
    if (!halted) begin
      if (want_operand) begin
        want_operand = 0;
        if (sp < DEPTH) begin
          stk[sp] = {56'd0, code};
          sp++;
        end
      end else begin
        run_opcode(code, is_last);
      end
    end
    if (!is_last) return;
    value = 64'd0;
    if (nbytes > MAXPROG) begin
      status = sbi_pkg::ST_INVALID;
      depth = 5'd0;
    end else begin
      status = err;
      depth = sp[4:0];
      if (status == sbi_pkg::ST_OK && sp > 0) value = stk[0];
    end
    pending_results.push_back({1'b0, depth, status, value});
    clear_state();
  endfunction

  // Compare one accepted output transfer with the oldest queued result.
  function void check_result(logic [71:0] got);
    logic [71:0] exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      n_errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    n_checked++;
    if (got[63:0] !== exp_r[63:0]) begin
      $display("%0t: result_value expected %h actual %h", $realtime, exp_r[63:0], got[63:0]);
      n_errors++;
    end
    if (got[65:64] !== exp_r[65:64]) begin
      $display("%0t: status expected %0d actual %0d", $realtime, exp_r[65:64], got[65:64]);
      n_errors++;
    end
    if (got[70:66] !== exp_r[70:66]) begin
      $display("%0t: final_depth expected %0d actual %0d", $realtime,
               exp_r[70:66], got[70:66]);
      n_errors++;
    end
  endfunction
endclass

module tb_stack_bytecode_interpreter;
  import sbi_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] code_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [63:0] result_value, [65:64] status, [70:66] final_depth

  stack_bytecode_interpreter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  interp_scoreboard sb;

  // Idle percentages for each side, changed per test phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          recv_hold;      // long hold-off of the output side
  int unsigned bytes_sent;
  int unsigned programs_sent;

  logic [7:0] prog_buf [$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Output side: randomly stall, or hold off entirely while recv_hold is set.
  // Check each result transfer as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte and hold it until the transfer completes; gaps precede it at random.
  // Drop tvalid only for a gap, so back-to-back bytes keep it high.
  task automatic send_byte(logic [7:0] code, bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(code, is_last);
    bytes_sent++;
  endtask

  // Send the queued program; the last byte carries tlast.
  task automatic send_program();
    int n;
    n = prog_buf.size();
    for (int i = 0; i < n; i++) send_byte(prog_buf[i], i == n - 1);
    prog_buf.delete();
    programs_sent++;
  endtask

  function automatic logic [7:0] rand_arith();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Build a mostly well-formed program: pushes followed by arithmetic, with
  // occasional noise bytes, pops, nops and halts. Division is kept rare since it is slow.
  task automatic build_random_program();
    int len, depth, kind;
    logic [7:0] op;
    len = $urandom_range(1, 8);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(99);
      if (kind < 3) begin
        prog_buf.push_back(8'($urandom_range(255)));
      end else if (kind < 6) begin
        prog_buf.push_back(OP_NOP);
      end else if (kind < 9) begin
        prog_buf.push_back(OP_POP);
        if (depth > 0) depth--;
      end else if (kind < 10) begin
        prog_buf.push_back(OP_HALT);
      end else if (depth < 2 || kind < 55) begin
        prog_buf.push_back(OP_PUSH);
        // bias operands toward zero and the top value
        case ($urandom_range(3))
          0: prog_buf.push_back(8'h00);
          1: prog_buf.push_back(8'hFF);
          default: prog_buf.push_back(8'($urandom_range(255)));
        endcase
        depth++;
      end else begin
        op = rand_arith();
        if (op == OP_DIV && $urandom_range(3) != 0) op = OP_MUL;
        prog_buf.push_back(op);
        depth--;
      end
    end
    // now and then end on a bare push to hit push-without-operand
    if (prog_buf.size() > 0 && $urandom_range(19) == 0) prog_buf.push_back(OP_PUSH);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic push_val(logic [7:0] v);
    prog_buf.push_back(OP_PUSH);
    prog_buf.push_back(v);
  endtask

  task automatic directed_programs();
    // every arithmetic op on extreme values
    push_val(8'hFF); push_val(8'hFF); prog_buf.push_back(OP_MUL); send_program();
    push_val(8'h00); push_val(8'h01); prog_buf.push_back(OP_SUB); send_program();
    push_val(8'hFF); push_val(8'h07); prog_buf.push_back(OP_DIV);
    push_val(8'h80); prog_buf.push_back(OP_ADD); send_program();
    // divide by zero
    push_val(8'h05); push_val(8'h00); prog_buf.push_back(OP_DIV); send_program();
    // underflow on pop and on arithmetic
    prog_buf.push_back(OP_POP); send_program();
    push_val(8'h03); prog_buf.push_back(OP_ADD); send_program();
    // unknown opcode, then bytes after stop
    prog_buf.push_back(8'h55); push_val(8'h01); send_program();
    // push on the last byte
    push_val(8'h09); prog_buf.push_back(OP_PUSH); send_program();
    // halt then junk, nop-only, empty stack
    push_val(8'hAA); prog_buf.push_back(OP_HALT); prog_buf.push_back(8'h77); send_program();
    prog_buf.push_back(OP_NOP); send_program();
  endtask

  task automatic overflow_programs();
    // fill the stack to exactly full, then overflow
    for (int i = 0; i < 16; i++) push_val(8'hF0 + i[7:0]);
    send_program();
    for (int i = 0; i < 16; i++) push_val(i[7:0]);
    prog_buf.push_back(OP_PUSH); prog_buf.push_back(8'h01); send_program();
  endtask

  task automatic long_programs();
    // one byte over the maximum length, with work at the start
    push_val(8'h21);
    for (int i = 0; i < 1023; i++) prog_buf.push_back(OP_NOP);
    send_program();
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sb.n_errors = 0;
    sb.n_checked = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 0;
    bytes_sent = 0;
    programs_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_programs();
    overflow_programs();

    // hold the output side off while a run of programs keeps arriving
    fork
      begin
        recv_hold = 1;
        repeat (600) @(posedge clk);
        recv_hold = 0;
      end
      begin
        for (int i = 0; i < 20; i++) begin
          push_val(8'($urandom_range(255))); send_program();
        end
      end
    join

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int i = 0; i < 6; i++) begin
        build_random_program();
        send_program();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_programs();

    wait_drained();
    $display("Covered %0d programs (%0d bytes), %0d results checked, four idling phases",
             programs_sent, bytes_sent, sb.n_checked);
    $display("including overflow, underflow, divide by zero and over-length programs.");
    if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_stack_bytecode_interpreter: clean");
    end else begin
      if (sb.pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $realtime, sb.pending_results.size());
      $display("tb_stack_bytecode_interpreter: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $realtime);
    $display("tb_stack_bytecode_interpreter: errors");
    $finish;
  end
endmodule
